FILE: rtl/lidar_frame_parser_defines.svh
// Assertion helpers shared by the frame parser RTL.
`ifndef LIDAR_FRAME_PARSER_DEFINES_SVH
`define LIDAR_FRAME_PARSER_DEFINES_SVH

// Clocked property, off while reset is asserted.
`define LFP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold at a clock edge.
`define LFP_NEVER(name, cond, msg) \
  `LFP_ASSERT(name, !(cond), msg)

`endif

FILE: rtl/lfp_pkg.sv
package lfp_pkg;

  localparam logic [7:0]  HeaderByte     = 8'h59;
  localparam logic [15:0] MaxDistReset   = 16'd1200;

  // Frame byte positions.
  localparam logic [3:0] PosFirstHdr  = 4'd0;
  localparam logic [3:0] PosSecondHdr = 4'd1;
  localparam logic [3:0] PosDistLo    = 4'd2;
  localparam logic [3:0] PosDistHi    = 4'd3;
  localparam logic [3:0] PosStrLo     = 4'd4;
  localparam logic [3:0] PosStrHi     = 4'd5;
  localparam logic [3:0] PosChecksum  = 4'd8;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_word_t;

  typedef struct packed {
    logic [15:0] distance_cm;
    logic [15:0] signal_strength;
    logic        reading_valid;
  } result_t;

  // Checksum-clean frame handed from the front to the back.
  typedef struct packed {
    logic [15:0] distance;
    logic [15:0] strength;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

FILE: rtl/lfp_stream_if.sv
interface lfp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/lfp_front.sv
`include "lidar_frame_parser_defines.svh"

module lfp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rx_valid_i,
  input  logic [7:0]                rx_byte_i,
  output logic                      rx_ready_o,
  input  lfp_pkg::fifo_status_t     fifo_status_i,
  output logic                      push_o,
  output lfp_pkg::frame_t           frame_o
);
  import lfp_pkg::*;

  logic [3:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] bytes_q [4];
  logic       accept;
  logic       store;
  logic [1:0] store_idx;
  logic [3:0] store_off;

  assign rx_ready_o = !fifo_status_i.full;
  assign accept     = rx_valid_i && rx_ready_o;
  assign store_off  = pos_q - PosDistLo;
  assign store_idx  = store_off[1:0];

  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    store  = 1'b0;
    push_o = 1'b0;
    if (accept) begin
      case (pos_q)
        PosSecondHdr: begin
          if (rx_byte_i == HeaderByte) begin
            sum_d = sum_q + rx_byte_i;
            pos_d = pos_q + 4'd1;
          end else begin
            pos_d = PosFirstHdr;
          end
        end
        PosDistLo, PosDistHi, PosStrLo, PosStrHi: begin
          store = 1'b1;
          sum_d = sum_q + rx_byte_i;
          pos_d = pos_q + 4'd1;
        end
        4'd6, 4'd7: begin
          sum_d = sum_q + rx_byte_i;
          pos_d = pos_q + 4'd1;
        end
        PosChecksum: begin
          // restart the hunt whatever the checksum says
          push_o = (rx_byte_i == sum_q);
          pos_d  = PosFirstHdr;
        end
        default: begin
          // first header byte; drop anything else
          if (rx_byte_i == HeaderByte) begin
            sum_d = rx_byte_i;
            pos_d = PosSecondHdr;
          end else begin
            pos_d = PosFirstHdr;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosFirstHdr;
      sum_q <= 8'd0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      bytes_q[store_idx] <= rx_byte_i;
    end
  end

  assign frame_o.distance = {bytes_q[1], bytes_q[0]};
  assign frame_o.strength = {bytes_q[3], bytes_q[2]};

  `LFP_ASSERT(a_pos_range, pos_q <= PosChecksum, "frame position out of range")
  `LFP_ASSERT(a_push_at_end, push_o |-> (pos_q == PosChecksum), "push away from checksum byte")
  `LFP_ASSERT(a_restart, (accept && pos_q == PosChecksum) |=> (pos_q == PosFirstHdr),
    "hunt did not restart after checksum byte")
endmodule

FILE: rtl/lfp_fifo.sv
`include "lidar_frame_parser_defines.svh"

module lfp_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lfp_pkg::frame_t       data_i,
  input  logic                  pop_i,
  output lfp_pkg::frame_t       data_o,
  output lfp_pkg::fifo_status_t status_o
);
  import lfp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  frame_t          mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign data_o         = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastIdx) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  `LFP_ASSERT(a_count_bound, count_q <= FullCnt, "queue count above depth")
  `LFP_NEVER(a_push_full, push_i && status_o.full, "push into full queue")
  `LFP_NEVER(a_pop_empty, pop_i && status_o.empty, "pop from empty queue")
endmodule

FILE: rtl/lfp_back.sv
`include "lidar_frame_parser_defines.svh"

module lfp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  input  lfp_pkg::fifo_status_t fifo_status_i,
  input  lfp_pkg::frame_t       frame_i,
  output logic                  pop_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output lfp_pkg::result_t      res_o
);
  import lfp_pkg::*;

  logic [15:0] limit_q;
  logic [15:0] held_dist_q, held_dist_d;
  logic [15:0] held_str_q, held_str_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;
  logic        in_range;

  assign pop_o    = !fifo_status_i.empty && (!out_valid_q || res_ready_i);
  assign in_range = (frame_i.distance != 16'd0) && (frame_i.distance <= limit_q);

  always_comb begin
    held_dist_d = held_dist_q;
    held_str_d  = held_str_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    if (pop_o) begin
      if (in_range) begin
        held_dist_d = frame_i.distance;
        held_str_d  = frame_i.strength;
      end
      out_d.distance_cm     = held_dist_d;
      out_d.signal_strength = held_str_d;
      out_d.reading_valid   = in_range;
      out_valid_d           = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= MaxDistReset;
      held_dist_q <= 16'd0;
      held_str_q  <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      held_dist_q <= held_dist_d;
      held_str_q  <= held_str_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  `LFP_ASSERT(a_valid_nonzero, (out_valid_q && out_q.reading_valid) |-> (out_q.distance_cm != 16'd0),
    "valid reading with zero distance")
  `LFP_ASSERT(a_held_match, (out_valid_q && out_q.reading_valid) |->
    (out_q.distance_cm == held_dist_q || $past(pop_o) == 1'b0 || pop_o),
    "held distance lost after valid reading")
  `LFP_ASSERT(a_out_hold, (out_valid_q && !res_ready_i) |=> (out_valid_q && $stable(out_q)),
    "result word changed while stalled")
endmodule

FILE: rtl/lidar_frame_parser.sv
// Nine-byte range-sensor frame parser: one received byte per word on rx_i.
// Throughput: one byte per clock, sustained; rx_i stalls only when the frame queue is full.
// A checksum-clean frame is written into the frame queue when its checksum byte is accepted,
// then popped by the back and registered as the result word at res_o.
// Reset (rst_ni, async, active low): hunt restarts at the first header byte, queue and
// output empty, held distance and strength zero, the distance limit (limit_q) back to 1200.

module lidar_frame_parser #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  lfp_stream_if.sink   rx_i,
  lfp_stream_if.source res_o
);
  import lfp_pkg::*;

  fifo_status_t fifo_status;
  frame_t       push_frame;
  frame_t       pop_frame;
  logic         push;
  logic         pop;

  // Front: track frame position and the running checksum, capture the
  // distance and strength bytes, and push only checksum-clean frames.
  lfp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_i.valid),
    .rx_byte_i     (rx_i.data.rx_byte),
    .rx_ready_o    (rx_i.ready),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .frame_o       (push_frame)
  );

  // Short queue: lets the front keep taking bytes while the result side
  // waits on a stalled sink.
  lfp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_frame),
    .pop_i    (pop),
    .data_o   (pop_frame),
    .status_o (fifo_status)
  );

  // Back: range check against the limit register, update the held pair,
  // and register the result word for the sink.
  lfp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fifo_status_i (fifo_status),
    .frame_i       (pop_frame),
    .pop_o         (pop),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .res_o         (res_o.data)
  );
endmodule
